@@ rtl/core/pdc_pkg.sv @@
// Shared types, widths and constants for the pump duty-cycle controller.
// Used by every module under rtl/core; depends on nothing else.
package pdc_pkg;

    // Width of the time stamps and of the elapsed-time arithmetic.
    localparam int TIME_WIDTH = 32;

    localparam int NOW_W    = 32;
    localparam int HOUR_W   = 5;
    localparam int MIN_W    = 11;
    localparam int LEFT_W   = 17;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [LEFT_W-1:0] SECS_PER_MIN = LEFT_W'(60);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_END   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RUN_MIN     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_REST_MIN    = CFG_IDX_W'(3);

    // Register values after reset.
    localparam logic [HOUR_W-1:0] FRAME_START_RST = HOUR_W'(6);
    localparam logic [HOUR_W-1:0] FRAME_END_RST   = HOUR_W'(18);
    localparam logic [MIN_W-1:0]  RUN_MIN_RST     = MIN_W'(30);
    localparam logic [MIN_W-1:0]  REST_MIN_RST    = MIN_W'(30);

    typedef logic [TIME_WIDTH-1:0] stamp_t;

    // Settings as the evaluation logic sees them, phase lengths in seconds.
    typedef struct packed {
        logic [HOUR_W-1:0] frame_start;
        logic [HOUR_W-1:0] frame_end;
        logic [LEFT_W-1:0] run_len;
        logic [LEFT_W-1:0] rest_len;
    } cfg_t;

    typedef struct packed {
        stamp_t            now;
        logic [HOUR_W-1:0] hour;
        logic              full;
    } item_t;

    typedef struct packed {
        logic              pump_on;
        logic              in_frame;
        logic              resting;
        logic [LEFT_W-1:0] seconds_left;
        logic              pump_changed;
    } result_t;

    // Phase length in seconds; 1440 minutes gives 86400, which fits LEFT_W.
    function automatic logic [LEFT_W-1:0] phase_len(input logic [MIN_W-1:0] minutes);
        logic [LEFT_W-1:0] prod;
        prod = LEFT_W'(LEFT_W'(minutes) * SECS_PER_MIN);
        return prod;
    endfunction

endpackage

@@ rtl/core/pdc_cfg_regs.sv @@
// Configuration register file of the pump duty-cycle controller.
// Depends on pdc_pkg for register indexes, reset values and cfg_t.
module pdc_cfg_regs
    import pdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    logic [HOUR_W-1:0] frame_start_reg;
    logic [HOUR_W-1:0] frame_end_reg;
    logic [MIN_W-1:0]  run_min_reg;
    logic [MIN_W-1:0]  rest_min_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_start_reg <= FRAME_START_RST;
            frame_end_reg   <= FRAME_END_RST;
            run_min_reg     <= RUN_MIN_RST;
            rest_min_reg    <= REST_MIN_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_FRAME_START: frame_start_reg <= wr_data[HOUR_W-1:0];
                REG_FRAME_END:   frame_end_reg   <= wr_data[HOUR_W-1:0];
                REG_RUN_MIN:     run_min_reg     <= wr_data[MIN_W-1:0];
                REG_REST_MIN:    rest_min_reg    <= wr_data[MIN_W-1:0];
                default:         ;
            endcase
        end
    end

    assign cfg.frame_start = frame_start_reg;
    assign cfg.frame_end   = frame_end_reg;
    assign cfg.run_len     = phase_len(run_min_reg);
    assign cfg.rest_len    = phase_len(rest_min_reg);

endmodule

@@ rtl/core/pdc_phase_core.sv @@
// Run/rest phase state and the evaluation of one item against it.
// Depends on pdc_pkg for cfg_t, item_t, result_t and the time width.
module pdc_phase_core
    import pdc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    eval_en,
    input  cfg_t    cfg,
    input  item_t   item,
    output result_t result
);

    logic   pump_reg,  pump_next;
    logic   rest_reg,  rest_next;
    logic   frame_reg, frame_next;
    stamp_t run_start_reg,  run_start_next;
    stamp_t rest_start_reg, rest_start_next;

    logic              in_win;
    logic              run_set, rest_set;
    stamp_t            run_el, rest_el;
    logic              run_over, rest_over;
    logic [LEFT_W-1:0] left;

    always_comb
    begin
        in_win   = (cfg.frame_start <= item.hour) && (item.hour < cfg.frame_end);
        run_set  = (run_start_reg != '0);
        rest_set = (rest_start_reg != '0);
        // An unset stamp is taken as now, so the elapsed time is zero.
        run_el   = run_set  ? (item.now - run_start_reg)  : '0;
        rest_el  = rest_set ? (item.now - rest_start_reg) : '0;
        run_over  = run_set  && (run_el  > TIME_WIDTH'(cfg.run_len));
        rest_over = rest_set && (rest_el > TIME_WIDTH'(cfg.rest_len));

        pump_next       = pump_reg;
        rest_next       = rest_reg;
        frame_next      = frame_reg;
        run_start_next  = run_start_reg;
        rest_start_next = rest_start_reg;
        left            = '0;

        if (item.full)
        begin
            // The frame flag is left as it was when the tank is full.
            pump_next       = 1'b0;
            rest_next       = 1'b0;
            run_start_next  = '0;
            rest_start_next = '0;
        end
        else if (in_win)
        begin
            frame_next = 1'b1;
            if (run_over && rest_over)
            begin
                rest_start_next = '0;
                run_start_next  = item.now;
                pump_next       = 1'b1;
                rest_next       = 1'b0;
                left            = cfg.run_len;
            end
            else if (run_over)
            begin
                if (!rest_set)
                begin
                    rest_start_next = item.now;
                end
                pump_next = 1'b0;
                rest_next = 1'b1;
                left      = cfg.rest_len - rest_el[LEFT_W-1:0];
            end
            else
            begin
                if (!run_set)
                begin
                    run_start_next = item.now;
                end
                pump_next = 1'b1;
                left      = cfg.run_len - run_el[LEFT_W-1:0];
            end
        end
        else
        begin
            pump_next       = 1'b0;
            rest_next       = 1'b0;
            frame_next      = 1'b0;
            run_start_next  = '0;
            rest_start_next = '0;
        end

        result.pump_on      = pump_next;
        result.in_frame     = frame_next;
        result.resting      = rest_next;
        result.seconds_left = left;
        result.pump_changed = pump_next ^ pump_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pump_reg       <= 1'b0;
            rest_reg       <= 1'b0;
            frame_reg      <= 1'b0;
            run_start_reg  <= '0;
            rest_start_reg <= '0;
        end
        else if (eval_en)
        begin
            pump_reg       <= pump_next;
            rest_reg       <= rest_next;
            frame_reg      <= frame_next;
            run_start_reg  <= run_start_next;
            rest_start_reg <= rest_start_next;
        end
    end

endmodule

@@ rtl/core/pump_duty_cycle_controller.sv @@
// Pump duty-cycle controller, top level: input register, result register
// and the handshakes. Depends on pdc_pkg, pdc_cfg_regs and pdc_phase_core.
//
// Each accepted beat on the input side yields exactly one result beat. A beat
// is held in the input register, evaluated against the phase state in a
// single pass of compares and subtractions, and then registered in the result
// register; it stays in the input register while in_stall is high. One beat
// per cycle is sustained while out_stall is low, since the phase state
// is updated in the same cycle that it is read. The input register takes a new
// beat while a result still waits to be taken; in_stall rises only when both
// registers are full and out_stall is high. Configuration writes are always
// ready and take effect on the next beat; they are meant to be issued while no
// beat is in flight.
module pump_duty_cycle_controller
    import pdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [NOW_W-1:0]      now_seconds,
    input  logic [HOUR_W-1:0]     hour_of_day,
    input  logic                  tank_full,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  pump_on,
    output logic                  in_frame,
    output logic                  resting,
    output logic [LEFT_W-1:0]     seconds_left,
    output logic                  pump_changed
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t result;
    result_t res_reg;
    logic    res_valid_reg;
    logic    advance;
    logic    fire;

    assign cfg_ready = 1'b1;

    pdc_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The result register can load whenever it is empty or being drained.
    assign advance  = !res_valid_reg || !out_stall;
    assign fire     = item_valid_reg && advance;
    assign in_stall = item_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg.now  <= TIME_WIDTH'(now_seconds);
            item_reg.hour <= hour_of_day;
            item_reg.full <= tank_full;
        end
    end

    pdc_phase_core u_phase_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .eval_en (fire),
        .cfg     (cfg),
        .item    (item_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            res_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= result;
        end
    end

    assign out_valid    = res_valid_reg;
    assign pump_on      = res_reg.pump_on;
    assign in_frame     = res_reg.in_frame;
    assign resting      = res_reg.resting;
    assign seconds_left = res_reg.seconds_left;
    assign pump_changed = res_reg.pump_changed;

`ifndef SYNTHESIS
    // The pump only ever runs inside the daily frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!pump_on || in_frame))
        else $error("pump reported on outside the frame");

    // A stopped pump that is not resting has no phase time left.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !pump_on && !resting) |-> (seconds_left == '0))
        else $error("time left reported while the pump is stopped");

    // An evaluated beat always shows up in the result register next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid)
        else $error("evaluated beat missing from the result register");
`endif

endmodule
